// File: rtl/core/ubd_pkg.sv
// Package: shared types and constants of the UTF-8 byte decoder.
`timescale 1ns / 1ps

package ubd_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CP_W      = 21;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TDATA_W   = 24;
  localparam int unsigned TRAIL_W   = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_VALID  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADHDR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CUT    = 2'd2;

  // Trailing-byte counts
  localparam logic [TRAIL_W-1:0] TRAIL_NONE  = 2'd0;
  localparam logic [TRAIL_W-1:0] TRAIL_ONE   = 2'd1;
  localparam logic [TRAIL_W-1:0] TRAIL_TWO   = 2'd2;
  localparam logic [TRAIL_W-1:0] TRAIL_THREE = 2'd3;

  // One decoded result
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CP_W-1:0]     code_point;
  } result_t;

endpackage

// File: rtl/core/utf8_byte_decoder.sv
// Top level: UTF-8 byte decoder with stream input and output channels.
`timescale 1ns / 1ps
//
// Usage:
//   Slave channel s_*: one raw UTF-8 byte per transfer in s_tdata.
//   Master channel m_*: one result per transfer; m_tdata carries the code
//   point, m_tuser the status (valid, invalid header, sequence cut short).
//   An ASCII byte or the last trailing byte of a sequence yields a code
//   point; an 11111xxx header yields an invalid-header result; an ASCII
//   byte in the middle of a sequence yields a cut-sequence result and is
//   dropped. Header and non-final trailing bytes yield no result, stray
//   trailing bytes are ignored.
//   Output: a result is registered in the result register, or in the skid register while the receiver stalls.
//   Throughput: one byte per cycle while s_tready is high, set by the single
//   decode stage between the input transfer and the result register.
//   Stall: a two-entry output buffer (result register plus skid register)
//   keeps s_tready high while one result waits; s_tready drops only once
//   the skid register is also full, and rises again when the receiver
//   takes a result.
//   Reset (rst, synchronous, active high) clears the trailing count, the
//   accumulator and the valid flags of both output entries.

module utf8_byte_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ubd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] byte_in
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ubd_pkg::TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic [ubd_pkg::STATUS_W-1:0] m_tuser   // [1:0] status
);

  logic [ubd_pkg::TRAIL_W-1:0] pending_trail, pending_trail_next;
  logic [ubd_pkg::CP_W-1:0]    accumulator, accumulator_next;
  logic                        emit;
  ubd_pkg::result_t            result_next;
  ubd_pkg::result_t            out_reg;
  ubd_pkg::result_t            skid_reg;
  logic                        skid_valid;
  logic                        in_xfer;
  logic                        out_xfer;
  logic [5:0]                  pay;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign s_tready = !skid_valid;
  assign pay      = s_tdata[5:0];

  // Decode one byte against the current trailing count
  always_comb begin
    pending_trail_next      = pending_trail;
    accumulator_next        = accumulator;
    emit                    = 1'b0;
    result_next.code_point  = '0;
    result_next.status      = ubd_pkg::ST_VALID;
    priority if (!s_tdata[7]) begin
      emit = 1'b1;
      if (pending_trail != ubd_pkg::TRAIL_NONE) begin
        pending_trail_next = ubd_pkg::TRAIL_NONE;
        accumulator_next   = '0;
        result_next.status = ubd_pkg::ST_CUT;
      end else begin
        result_next.code_point = {13'd0, s_tdata};
      end
    end else if (s_tdata[6]) begin
      priority if (!s_tdata[5]) begin
        pending_trail_next = ubd_pkg::TRAIL_ONE;
        accumulator_next   = {10'd0, s_tdata[4:0], 6'd0};
      end else if (!s_tdata[4]) begin
        pending_trail_next = ubd_pkg::TRAIL_TWO;
        accumulator_next   = {5'd0, s_tdata[3:0], 12'd0};
      end else if (!s_tdata[3]) begin
        pending_trail_next = ubd_pkg::TRAIL_THREE;
        accumulator_next   = {s_tdata[2:0], 18'd0};
      end else begin
        pending_trail_next = ubd_pkg::TRAIL_NONE;
        accumulator_next   = '0;
        emit               = 1'b1;
        result_next.status = ubd_pkg::ST_BADHDR;
      end
    end else begin
      unique case (pending_trail)
        ubd_pkg::TRAIL_ONE: begin
          emit                   = 1'b1;
          result_next.code_point = accumulator | {15'd0, pay};
          pending_trail_next     = ubd_pkg::TRAIL_NONE;
          accumulator_next       = '0;
        end
        ubd_pkg::TRAIL_TWO: begin
          accumulator_next   = accumulator | {9'd0, pay, 6'd0};
          pending_trail_next = ubd_pkg::TRAIL_ONE;
        end
        ubd_pkg::TRAIL_THREE: begin
          accumulator_next   = accumulator | {3'd0, pay, 12'd0};
          pending_trail_next = ubd_pkg::TRAIL_TWO;
        end
        default: begin
          // stray trailing byte: drop it, hold state
          pending_trail_next = pending_trail;
        end
      endcase
    end
  end

  // Advance decode state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_trail <= ubd_pkg::TRAIL_NONE;
      accumulator   <= '0;
    end else if (in_xfer) begin
      pending_trail <= pending_trail_next;
      accumulator   <= accumulator_next;
    end
  end

  // Result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (in_xfer && emit) begin
      if (!m_tvalid || out_xfer) begin
        out_reg  <= result_next;
        m_tvalid <= 1'b1;
      end else begin
        skid_reg   <= result_next;
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {3'd0, out_reg.code_point};
  assign m_tuser = out_reg.status;

  // Checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held while result register empty");

  a_error_zero_cp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ubd_pkg::ST_VALID) |-> (m_tdata == '0))
    else $error("error result carries a nonzero code point");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ubd_pkg::ST_VALID || m_tuser == ubd_pkg::ST_BADHDR ||
                  m_tuser == ubd_pkg::ST_CUT))
    else $error("undefined status code on output");

  a_ascii_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !s_tdata[7]) |=> m_tvalid)
    else $error("ASCII byte transfer produced no result");

endmodule
